// File: hw/rtl/llqm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llqm_pkg
// Shared constants, operation codes and control structs for the linked-list
// queue manager.
// ----------------------------------------------------------------------------
package llqm_pkg;

   // field widths fixed by the stream format
   localparam int HANDLE_W    = 8;
   localparam int HANDLE_SPAN = 2 ** HANDLE_W;
   localparam int DATA_W      = 32;
   localparam int MODE_W      = 2;
   localparam int LINK_W      = HANDLE_W + 1;

   // packed stream widths
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;

   // default sizing
   localparam int NODE_COUNT_DEF  = 256;
   localparam int VALUE_WIDTH_DEF = 32;

   // operation codes
   localparam logic [MODE_W-1:0] MODE_ENQUEUE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DEQUEUE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_INIT    = 2'd2;

   // controller to datapath commands, one cycle each
   typedef struct packed {
      logic capture;       // latch the request fields
      logic link_rd;       // read link of the head node
      logic link_wr_node;  // clear link of the supplied node
      logic link_wr_tail;  // link the supplied node after the tail
      logic value_wr;      // store the value into the supplied node
      logic value_rd;      // read value of the node after the head
      logic set_init;      // head and tail to the supplied node
      logic set_tail;      // tail to the supplied node
      logic advance;       // head moves to the next node
      logic load_rsp;      // load the result register
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic [MODE_W-1:0] in_mode;     // mode of the offered request
      logic              link_valid;  // head has a successor
   } status_type;

endpackage

// File: hw/rtl/linked_list_queue_manager_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linked_list_queue_manager_top
// FIFO queue kept as a linked list over a node pool with a dummy head node.
// Each request enqueues, dequeues, initializes or is a no-op; one response each.
// ----------------------------------------------------------------------------
//   channel  direction  tdata                                  tuser
//   req      in         [7:0] node_handle, [39:8] data_value   [1:0] mode
//   rsp      out        [31:0] out_value, [39:32] released     [0] success
// One request is in flight at a time. Enqueue steps through node, tail and
// done states, dequeue through link and done, initialize through init and
// done, and an unused mode only through done; the single-port link store
// sets these steps (two link writes per enqueue, registered link then value
// read per dequeue). The response register lets a new request in while a
// response waits; a stalled response holds the sequencer in its final step.
// Reset is synchronous; the queue restarts empty with node 0 as dummy.
// ----------------------------------------------------------------------------
module linked_list_queue_manager_top #(
   parameter int NODE_COUNT  = llqm_pkg::NODE_COUNT_DEF,
   parameter int VALUE_WIDTH = llqm_pkg::VALUE_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [llqm_pkg::REQ_TDATA_W-1:0]    req_tdata,  // node_handle, data_value
   input  logic [llqm_pkg::MODE_W-1:0]         req_tuser,  // mode
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [llqm_pkg::RSP_TDATA_W-1:0]    rsp_tdata,  // out_value, released_node
   output logic                                rsp_tuser   // success
);

   llqm_pkg::cmd_type             cmd;
   llqm_pkg::status_type          status;
   logic [llqm_pkg::DATA_W-1:0]   rsp_value;
   logic [llqm_pkg::HANDLE_W-1:0] rsp_node;

   // sequencer
   llqm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // pool and pointers
   llqm_datapath #(
      .NODE_COUNT  (NODE_COUNT),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .in_mode     (req_tuser),
      .in_handle   (req_tdata[llqm_pkg::HANDLE_W-1:0]),
      .in_data     (req_tdata[llqm_pkg::HANDLE_W +: llqm_pkg::DATA_W]),
      .cmd         (cmd),
      .status      (status),
      .rsp_success (rsp_tuser),
      .rsp_value   (rsp_value),
      .rsp_node    (rsp_node)
   );

   // response packing
   assign rsp_tdata = {rsp_node, rsp_value};

endmodule

// File: hw/rtl/llqm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llqm_ctrl
// Operation sequencer: steps each request through its memory accesses and
// owns the handshake of both stream channels.
// ----------------------------------------------------------------------------
module llqm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  llqm_pkg::status_type status,
   output llqm_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ENQ_NODE,
      S_ENQ_TAIL,
      S_INIT,
      S_DEQ_LINK,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_xfer;
   logic      slot_free;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign req_xfer   = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   // next state, commands and result slot
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               cmd.capture = 1'b1;
               cmd.link_rd = 1'b1;
               case (status.in_mode)
                  llqm_pkg::MODE_ENQUEUE: state_in = S_ENQ_NODE;
                  llqm_pkg::MODE_DEQUEUE: state_in = S_DEQ_LINK;
                  llqm_pkg::MODE_INIT:    state_in = S_INIT;
                  default:                state_in = S_DONE;
               endcase
            end
         end
         S_ENQ_NODE: begin
            cmd.link_wr_node = 1'b1;
            cmd.value_wr     = 1'b1;
            state_in         = S_ENQ_TAIL;
         end
         S_ENQ_TAIL: begin
            cmd.link_wr_tail = 1'b1;
            cmd.set_tail     = 1'b1;
            state_in         = S_DONE;
         end
         S_INIT: begin
            cmd.link_wr_node = 1'b1;
            cmd.set_init     = 1'b1;
            state_in         = S_DONE;
         end
         S_DEQ_LINK: begin
            cmd.value_rd = 1'b1;
            cmd.advance  = status.link_valid;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: hw/rtl/llqm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llqm_datapath
// Node pool memories, head and tail pointers, request capture and result
// register for the linked-list queue manager.
// ----------------------------------------------------------------------------
module llqm_datapath #(
   parameter int NODE_COUNT  = llqm_pkg::NODE_COUNT_DEF,
   parameter int VALUE_WIDTH = llqm_pkg::VALUE_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [llqm_pkg::MODE_W-1:0]      in_mode,
   input  logic [llqm_pkg::HANDLE_W-1:0]    in_handle,
   input  logic [llqm_pkg::DATA_W-1:0]      in_data,
   input  llqm_pkg::cmd_type                cmd,
   output llqm_pkg::status_type             status,
   output logic                             rsp_success,
   output logic [llqm_pkg::DATA_W-1:0]      rsp_value,
   output logic [llqm_pkg::HANDLE_W-1:0]    rsp_node
);

   localparam int AW = $clog2(NODE_COUNT);

   typedef logic [llqm_pkg::HANDLE_SPAN-1:0][llqm_pkg::HANDLE_W-1:0] node_map_type;

   // handle reduction to the pool size, built at elaboration
   function automatic node_map_type build_node_map();
      node_map_type m;
      for (int i = 0; i < llqm_pkg::HANDLE_SPAN; i++) begin
         m[i] = llqm_pkg::HANDLE_W'(i % NODE_COUNT);
      end
      return m;
   endfunction

   localparam node_map_type NODE_MAP = build_node_map();

   // node pool
   logic [llqm_pkg::LINK_W-1:0] link_mem  [NODE_COUNT];
   logic [VALUE_WIDTH-1:0]      value_mem [NODE_COUNT];

   logic [llqm_pkg::MODE_W-1:0]   mode_ff;
   logic [llqm_pkg::HANDLE_W-1:0] node_ff;
   logic [VALUE_WIDTH-1:0]        data_ff;
   logic [llqm_pkg::HANDLE_W-1:0] head_ff;
   logic [llqm_pkg::HANDLE_W-1:0] tail_ff;
   logic [llqm_pkg::HANDLE_W-1:0] old_head_ff;
   logic [llqm_pkg::LINK_W-1:0]   link_rd_ff;
   logic                          link_blank_ff;
   logic [VALUE_WIDTH-1:0]        value_rd_ff;
   logic                          link0_written_ff;
   logic                          success_ff;
   logic [llqm_pkg::DATA_W-1:0]   value_ff;
   logic [llqm_pkg::HANDLE_W-1:0] released_ff;

   logic                          link_we;
   logic [llqm_pkg::HANDLE_W-1:0] link_waddr;
   logic [llqm_pkg::LINK_W-1:0]   link_wdata;
   logic                          link_valid;
   logic [llqm_pkg::HANDLE_W-1:0] next_node;
   logic                          is_dequeue;

   // link store write port
   assign link_we    = cmd.link_wr_node || cmd.link_wr_tail;
   assign link_waddr = cmd.link_wr_tail ? tail_ff : node_ff;
   assign link_wdata = cmd.link_wr_tail ? {1'b1, node_ff} : '0;

   // entry 0 reads as null until it is written
   assign link_valid = link_rd_ff[llqm_pkg::HANDLE_W] && !link_blank_ff;
   assign next_node  = link_rd_ff[llqm_pkg::HANDLE_W-1:0];
   assign is_dequeue = (mode_ff == llqm_pkg::MODE_DEQUEUE);

   assign status.in_mode    = in_mode;
   assign status.link_valid = link_valid;

   assign rsp_success = success_ff;
   assign rsp_value   = value_ff;
   assign rsp_node    = released_ff;

   // link store
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[AW'(link_waddr)] <= link_wdata;
      end
      if (cmd.link_rd) begin
         link_rd_ff    <= link_mem[AW'(head_ff)];
         link_blank_ff <= (head_ff == '0) && !link0_written_ff;
      end
   end

   // value store
   always_ff @(posedge clock) begin
      if (cmd.value_wr) begin
         value_mem[AW'(node_ff)] <= data_ff;
      end
      if (cmd.value_rd) begin
         value_rd_ff <= value_mem[AW'(next_node)];
      end
   end

   // request capture and result payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= in_mode;
         node_ff <= NODE_MAP[in_handle];
         data_ff <= VALUE_WIDTH'(in_data);
      end
      if (cmd.link_rd) begin
         old_head_ff <= head_ff;
      end
      if (cmd.load_rsp) begin
         success_ff  <= (mode_ff == llqm_pkg::MODE_ENQUEUE) ||
                        (mode_ff == llqm_pkg::MODE_INIT) ||
                        (is_dequeue && link_valid);
         value_ff    <= (is_dequeue && link_valid) ?
                        llqm_pkg::DATA_W'(value_rd_ff) : '0;
         released_ff <= is_dequeue ? old_head_ff : '0;
      end
   end

   // head and tail pointers, entry 0 write flag
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff          <= '0;
         tail_ff          <= '0;
         link0_written_ff <= 1'b0;
      end else begin
         if (link_we && (link_waddr == '0)) begin
            link0_written_ff <= 1'b1;
         end
         if (cmd.set_init) begin
            head_ff <= node_ff;
            tail_ff <= node_ff;
         end else if (cmd.set_tail) begin
            tail_ff <= node_ff;
         end else if (cmd.advance) begin
            head_ff <= next_node;
            if (tail_ff == head_ff) begin
               tail_ff <= next_node;
            end
         end
      end
   end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the linked-list queue manager. A scoreboard class
// keeps its own copy of the node pool, head and tail, predicts one response
// per accepted request and checks every response transfer field by field.
// Stimulus is a short directed run, then mostly well-formed traffic: nodes
// are enqueued from the free part of the pool with random data. Noise is
// mixed in: unused modes, enqueues and initializes on arbitrary nodes, and
// dequeues on arbitrary handles. Both sides idle at random in several phases,
// and the response side holds off for a long stretch once.
// ----------------------------------------------------------------------------
module testbench;

   localparam logic [llqm_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int PHASE_ITEMS    = 360;
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 20;
   localparam int WATCHDOG_LIMIT = 4000;

   // one response as the block reports it
   typedef struct packed {
      logic                          success;
      logic [llqm_pkg::DATA_W-1:0]   out_value;
      logic [llqm_pkg::HANDLE_W-1:0] released_node;
   } queue_result_type;

   // ------------------------------------------------------------------------
   // queue scoreboard: private copy of the pool and the expected responses
   // ------------------------------------------------------------------------
   class queue_scoreboard;
      bit [llqm_pkg::LINK_W-1:0]   link_store [llqm_pkg::HANDLE_SPAN];
      bit [llqm_pkg::DATA_W-1:0]   value_store [llqm_pkg::HANDLE_SPAN];
      bit [llqm_pkg::HANDLE_W-1:0] head_node;
      bit [llqm_pkg::HANDLE_W-1:0] tail_node;
      queue_result_type            pending_results [$];
      int error_count;
      int enqueue_count;
      int dequeue_hit_count;
      int dequeue_empty_count;
      int init_count;
      int unused_count;
      int checked_count;

      // apply one accepted request and queue its response
      function void note_request(logic [llqm_pkg::MODE_W-1:0] mode,
                                 logic [llqm_pkg::HANDLE_W-1:0] handle,
                                 logic [llqm_pkg::DATA_W-1:0] value);
         queue_result_type            result;
         bit [llqm_pkg::LINK_W-1:0]   head_link;
         bit [llqm_pkg::HANDLE_W-1:0] next_node;
         result = '0;
         case (mode)
            llqm_pkg::MODE_ENQUEUE: begin
               // clear the node first, so enqueue of the tail links it to itself
               value_store[handle] = value;
               link_store[handle]  = '0;
               link_store[tail_node] = {1'b1, handle};
               tail_node = handle;
               result.success = 1'b1;
               enqueue_count++;
            end
            llqm_pkg::MODE_DEQUEUE: begin
               head_link = link_store[head_node];
               result.released_node = head_node;
               if (head_link[llqm_pkg::LINK_W-1]) begin
                  next_node = head_link[llqm_pkg::HANDLE_W-1:0];
                  result.success   = 1'b1;
                  result.out_value = value_store[next_node];
                  if (tail_node == head_node) tail_node = next_node;
                  head_node = next_node;
                  dequeue_hit_count++;
               end else begin
                  dequeue_empty_count++;
               end
            end
            llqm_pkg::MODE_INIT: begin
               link_store[handle] = '0;
               head_node = handle;
               tail_node = handle;
               result.success = 1'b1;
               init_count++;
            end
            default: begin
               // unused mode leaves the queue alone
               unused_count++;
            end
         endcase
         pending_results.push_back(result);
      endfunction

      // compare one response transfer with the oldest expectation
      function void check_response(logic success, logic [llqm_pkg::DATA_W-1:0] out_value,
                                   logic [llqm_pkg::HANDLE_W-1:0] released_node);
         queue_result_type want;
         if (pending_results.size() == 0) begin
            $error("response transfer with no request outstanding");
            error_count++;
            return;
         end
         want = pending_results.pop_front();
         checked_count++;
         if (success !== want.success) begin
            $error("success: expected %0d, actual %0d", want.success, success);
            error_count++;
         end
         if (out_value !== want.out_value) begin
            $error("out_value: expected %h, actual %h", want.out_value, out_value);
            error_count++;
         end
         if (released_node !== want.released_node) begin
            $error("released_node: expected %0d, actual %0d",
                   want.released_node, released_node);
            error_count++;
         end
      endfunction

      // a random node not on the chain from head to tail
      function void pick_free_node(output bit found,
                                   output logic [llqm_pkg::HANDLE_W-1:0] node);
         bit                            in_use [llqm_pkg::HANDLE_SPAN];
         logic [llqm_pkg::HANDLE_W-1:0] walk;
         logic [llqm_pkg::HANDLE_W-1:0] free_nodes [$];
         int                            steps;
         walk = head_node;
         in_use[walk] = 1'b1;
         in_use[tail_node] = 1'b1;
         steps = 0;
         while (walk != tail_node && link_store[walk][llqm_pkg::LINK_W-1] &&
                steps < llqm_pkg::HANDLE_SPAN) begin
            walk = link_store[walk][llqm_pkg::HANDLE_W-1:0];
            in_use[walk] = 1'b1;
            steps++;
         end
         for (int i = 0; i < llqm_pkg::HANDLE_SPAN; i++)
            if (!in_use[i]) free_nodes.push_back(i[llqm_pkg::HANDLE_W-1:0]);
         found = (free_nodes.size() != 0);
         node = found ? free_nodes[$urandom_range(free_nodes.size() - 1)] : '0;
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // block signals and instance
   // ------------------------------------------------------------------------
   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [llqm_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;  // node_handle, data_value
   logic [llqm_pkg::MODE_W-1:0]      req_tuser  = '0;  // mode
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [llqm_pkg::RSP_TDATA_W-1:0] rsp_tdata;        // out_value, released_node
   logic                             rsp_tuser;        // success

   queue_scoreboard board;
   int  sender_idle_pct   = 0;
   int  receiver_stall_pct = 0;
   bit  hold_request      = 1'b0;
   int  hold_left         = 0;
   int  quiet_cycles      = 0;

   linked_list_queue_manager_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // request driver
   // ------------------------------------------------------------------------
   task automatic send_request(input logic [llqm_pkg::MODE_W-1:0] mode,
                               input logic [llqm_pkg::HANDLE_W-1:0] handle,
                               input logic [llqm_pkg::DATA_W-1:0] value);
      // random gap before the transfer
      if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {value, handle};
      do @(posedge clock); while (req_tready !== 1'b1);
      board.note_request(mode, handle, value);
   endtask

   // mostly random data, some corner patterns
   function automatic logic [llqm_pkg::DATA_W-1:0] random_value();
      int bit_pos;
      bit_pos = $urandom_range(llqm_pkg::DATA_W - 1);
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2:       return 32'h1 << bit_pos;
         3:       return ~(32'h1 << bit_pos);
         default: return $urandom;
      endcase
   endfunction

   // any handle, extremes included
   function automatic logic [llqm_pkg::HANDLE_W-1:0] random_handle();
      return llqm_pkg::HANDLE_W'($urandom_range(255));
   endfunction

   // one random request; enqueue_pct steers the queue depth
   task automatic send_random_item(input int enqueue_pct);
      int                            pick;
      bit                            found;
      logic [llqm_pkg::HANDLE_W-1:0] node;
      pick = $urandom_range(99);
      board.pick_free_node(found, node);
      if (pick < 8) begin
         // noise: modes and nodes a careful caller would not use
         case ($urandom_range(3))
            0: send_request(MODE_UNUSED, random_handle(), $urandom);
            1: send_request(llqm_pkg::MODE_ENQUEUE, random_handle(), random_value());
            2: send_request(llqm_pkg::MODE_INIT, random_handle(), $urandom);
            default: send_request(llqm_pkg::MODE_DEQUEUE, random_handle(), $urandom);
         endcase
      end else if (pick == 8 && found) begin
         send_request(llqm_pkg::MODE_INIT, node, $urandom);
      end else if (found && $urandom_range(99) < enqueue_pct) begin
         send_request(llqm_pkg::MODE_ENQUEUE, node, random_value());
      end else begin
         send_request(llqm_pkg::MODE_DEQUEUE, random_handle(), $urandom);
      end
   endtask

   // directed sequence over the field extremes and the corner cases
   task automatic run_directed();
      send_request(llqm_pkg::MODE_DEQUEUE, 8'd0, 32'h0);           // empty after reset
      send_request(MODE_UNUSED, 8'd255, 32'hFFFF_FFFF);
      send_request(llqm_pkg::MODE_ENQUEUE, 8'd255, 32'hFFFF_FFFF);
      send_request(llqm_pkg::MODE_ENQUEUE, 8'd1, 32'h0000_0000);
      send_request(llqm_pkg::MODE_DEQUEUE, 8'd255, 32'hFFFF_FFFF);
      send_request(llqm_pkg::MODE_DEQUEUE, 8'd0, 32'h0);
      send_request(llqm_pkg::MODE_DEQUEUE, 8'd0, 32'h0);           // empty again
      send_request(llqm_pkg::MODE_ENQUEUE, 8'd1, 32'hA5A5_A5A5);   // tail node, self link
      send_request(llqm_pkg::MODE_DEQUEUE, 8'd0, 32'h0);
      send_request(llqm_pkg::MODE_DEQUEUE, 8'd0, 32'h0);
      send_request(llqm_pkg::MODE_INIT, 8'd0, 32'hFFFF_FFFF);
      send_request(llqm_pkg::MODE_ENQUEUE, 8'd128, 32'h5A5A_5A5A);
      send_request(llqm_pkg::MODE_ENQUEUE, 8'd0, 32'h0000_0001);   // enqueue of the head
      send_request(llqm_pkg::MODE_DEQUEUE, 8'd0, 32'h0);
      send_request(llqm_pkg::MODE_INIT, 8'd200, 32'h0);
      send_request(llqm_pkg::MODE_DEQUEUE, 8'd0, 32'h0);
      send_request(llqm_pkg::MODE_ENQUEUE, 8'd7, 32'h1234_5678);
      send_request(llqm_pkg::MODE_ENQUEUE, 8'd9, 32'h8000_0000);
      send_request(llqm_pkg::MODE_ENQUEUE, 8'd10, 32'h0000_0001);
      send_request(llqm_pkg::MODE_DEQUEUE, 8'd0, 32'h0);
      send_request(llqm_pkg::MODE_DEQUEUE, 8'd0, 32'h0);
      send_request(llqm_pkg::MODE_DEQUEUE, 8'd0, 32'h0);
      send_request(MODE_UNUSED, 8'd0, 32'h0);
      send_request(llqm_pkg::MODE_DEQUEUE, 8'd0, 32'h0);
   endtask

   // ------------------------------------------------------------------------
   // response side: check transfers, random stalls and one long hold-off
   // ------------------------------------------------------------------------
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
            board.check_response(rsp_tuser, rsp_tdata[llqm_pkg::DATA_W-1:0],
               rsp_tdata[llqm_pkg::DATA_W+llqm_pkg::HANDLE_W-1:llqm_pkg::DATA_W]);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // watchdog on cycles without any transfer
   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid === 1'b1 && req_tready === 1'b1) ||
             (rsp_tvalid === 1'b1 && rsp_tready === 1'b1))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("testbench: done, errors");
      $finish;
   end

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      int sender_idle [4];
      int receiver_stall [4];
      int bias_choices [4];
      int enqueue_pct;
      sender_idle    = '{0, 61, 0, 31};
      receiver_stall = '{0, 0, 61, 31};
      bias_choices   = '{20, 50, 80, 95};
      enqueue_pct    = 50;
      board = new();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      // random phases with different idling on each side
      for (int phase = 0; phase < 4; phase++) begin
         sender_idle_pct    = sender_idle[phase];
         receiver_stall_pct = receiver_stall[phase];
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i % 50 == 0) enqueue_pct = bias_choices[$urandom_range(3)];
            if (phase == 0 && i == 150) hold_request = 1'b1;
            send_random_item(enqueue_pct);
         end
      end
      req_tvalid <= 1'b0;

      // drain outstanding responses, then let the bench run quiet before the report
      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d enqueues, %0d dequeues with data, %0d on an empty queue,",
               board.enqueue_count, board.dequeue_hit_count, board.dequeue_empty_count);
      $display("%0d initializes, %0d unused modes; %0d responses checked, %0d mismatches",
               board.init_count, board.unused_count, board.checked_count,
               board.error_count);
      if (board.error_count == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/llqm_pkg.sv
hw/rtl/llqm_ctrl.sv
hw/rtl/llqm_datapath.sv
hw/rtl/linked_list_queue_manager_top.sv
bench/testbench.sv
